@@ sv/pctm_pkg.sv @@
// Shared constants, types and field layout for the pulse capture trip meter.
`default_nettype none
package pctm_pkg;

  // Capture timer ticks per microsecond.
  localparam int TICKS_PER_US = 80;

  localparam int CAP_W = 32;
  localparam int US_W  = 26;
  localparam logic [US_W-1:0] US_MAX = {US_W{1'b1}};
  localparam logic [US_W-1:0] RPM_NUMERATOR = US_W'(60000000);

  // Tick-to-microsecond divider: 33-bit dividend, one quotient bit per cycle.
  localparam int CDIV_IN_W  = CAP_W + 1;
  localparam int CDIV_CNT_W = $clog2(CDIV_IN_W + 1);
  localparam int CDIV_REM_W = $clog2(TICKS_PER_US) + 1;
  localparam logic [CDIV_REM_W:0] CDIV_DIVISOR = (CDIV_REM_W + 1)'(TICKS_PER_US);

  // Rpm divider: constant numerator over a 26-bit period.
  localparam int RDIV_CNT_W = $clog2(US_W + 1);

  // Result word layout, lowest field first.
  localparam int OUT_WIDTH_LSB   = 0;
  localparam int OUT_PERIOD_LSB  = OUT_WIDTH_LSB + US_W;
  localparam int OUT_RPM_LSB     = OUT_PERIOD_LSB + US_W;
  localparam int OUT_SPEED_LSB   = OUT_RPM_LSB + US_W;
  localparam int OUT_COUNT_LSB   = OUT_SPEED_LSB + US_W;
  localparam int OUT_STOPPED_BIT = OUT_COUNT_LSB + CAP_W;
  localparam int OUT_BITS        = OUT_STOPPED_BIT + 1;
  localparam int OUT_TDATA_W     = ((OUT_BITS + 7) / 8) * 8;
  localparam int OUT_PAD         = OUT_TDATA_W - OUT_BITS;

  localparam int IN_TDATA_W = 2 * CAP_W;

  typedef enum logic [1:0] {
    CMD_INJ_PULSE     = 2'd0,
    CMD_SPEED_PULSE   = 2'd1,
    CMD_INJ_TIMEOUT   = 2'd2,
    CMD_SPEED_TIMEOUT = 2'd3
  } cmd_t;

  localparam logic REG_INJ_WIDTH_LIMIT    = 1'b0;
  localparam logic REG_SPEED_PERIOD_LIMIT = 1'b1;

  // Handshake between the sequencer and a serial divider.
  typedef struct packed {
    logic start;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_rsp_t;

endpackage
`default_nettype wire

@@ sv/pctm_cdiv.sv @@
// Bit-serial divider of a tick count by the ticks per microsecond, saturated to 26 bits.
`default_nettype none
module pctm_cdiv (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire pctm_pkg::div_req_t                 req,
  input  wire logic [pctm_pkg::CDIV_IN_W-1:0]     dividend,
  output pctm_pkg::div_rsp_t                      rsp,
  output logic [pctm_pkg::US_W-1:0]               quotient
);

  logic [pctm_pkg::CDIV_IN_W-1:0]  dvd;
  logic [pctm_pkg::CDIV_IN_W-1:0]  quo;
  logic [pctm_pkg::CDIV_REM_W-1:0] rem;
  logic [pctm_pkg::CDIV_CNT_W-1:0] cnt;
  logic                            busy;
  logic                            done;

  logic [pctm_pkg::CDIV_REM_W:0]   trial;
  logic                            qbit;
  logic [pctm_pkg::CDIV_REM_W-1:0] rem_next;

  // Restoring division: shift in one dividend bit, subtract when it fits.
  always_comb begin
    trial = {rem, dvd[pctm_pkg::CDIV_IN_W-1]};
    qbit  = (trial >= pctm_pkg::CDIV_DIVISOR);
    if (qbit) begin
      rem_next = pctm_pkg::CDIV_REM_W'(trial - pctm_pkg::CDIV_DIVISOR);
    end else begin
      rem_next = trial[pctm_pkg::CDIV_REM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        dvd  <= dividend;
        rem  <= '0;
      end else if (busy) begin
        dvd <= {dvd[pctm_pkg::CDIV_IN_W-2:0], 1'b0};
        rem <= rem_next;
        quo <= {quo[pctm_pkg::CDIV_IN_W-2:0], qbit};
        cnt <= cnt + 1'b1;
        if (cnt == pctm_pkg::CDIV_CNT_W'(pctm_pkg::CDIV_IN_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    rsp.busy = busy;
    rsp.done = done;
    if (quo[pctm_pkg::CDIV_IN_W-1:pctm_pkg::US_W] != '0) begin
      quotient = pctm_pkg::US_MAX;
    end else begin
      quotient = quo[pctm_pkg::US_W-1:0];
    end
  end

endmodule
`default_nettype wire

@@ sv/pctm_rdiv.sv @@
// Bit-serial divider of the rpm numerator by the injector period in microseconds.
`default_nettype none
module pctm_rdiv (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire pctm_pkg::div_req_t            req,
  input  wire logic [pctm_pkg::US_W-1:0]     divisor,
  output pctm_pkg::div_rsp_t                 rsp,
  output logic [pctm_pkg::US_W-1:0]          quotient
);

  logic [pctm_pkg::US_W-1:0]       num;
  logic [pctm_pkg::US_W-1:0]       dsr;
  logic [pctm_pkg::US_W-1:0]       rem;
  logic [pctm_pkg::US_W-1:0]       quo;
  logic [pctm_pkg::RDIV_CNT_W-1:0] cnt;
  logic                            busy;
  logic                            done;

  logic [pctm_pkg::US_W:0]         trial;
  logic                            qbit;
  logic [pctm_pkg::US_W-1:0]       rem_next;

  always_comb begin
    trial = {rem, num[pctm_pkg::US_W-1]};
    qbit  = (trial >= {1'b0, dsr});
    if (qbit) begin
      rem_next = pctm_pkg::US_W'(trial - {1'b0, dsr});
    end else begin
      rem_next = trial[pctm_pkg::US_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        num  <= pctm_pkg::RPM_NUMERATOR;
        dsr  <= divisor;
        rem  <= '0;
      end else if (busy) begin
        num <= {num[pctm_pkg::US_W-2:0], 1'b0};
        rem <= rem_next;
        quo <= {quo[pctm_pkg::US_W-2:0], qbit};
        cnt <= cnt + 1'b1;
        if (cnt == pctm_pkg::RDIV_CNT_W'(pctm_pkg::US_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign quotient = quo;

endmodule
`default_nettype wire

@@ sv/pulse_capture_trip_meter_unit.sv @@
// Top level: event sequencer, measurement state and result register of the trip meter.
// Timeouts and unarmed or stopped pulses go from ST_CALC straight to ST_OUT; a pulse over
// its limit passes ST_CHECK; a speed period or an injector pulse with a zero period ends
// after the tick division; an injector pulse runs two 33-step tick dividers in parallel,
// then the 26-step rpm divider. The result load waits while an earlier result is stalled.
// Events are handled one at a time; the next word can be taken in the cycle after the
// result word is loaded, even while that result still waits.
// Synchronous reset clears all measurements, disarms the injector channel, sets the
// stopped flag and loads both limits with all ones.
`default_nettype none
module pulse_capture_trip_meter_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // first_capture[31:0], second_capture[63:32]
  input  wire logic [pctm_pkg::IN_TDATA_W-1:0]     s_tdata,
  // cmd[1:0]
  input  wire logic [1:0]                          s_tuser,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // inj_width_us[25:0], inj_period_us[51:26], engine_rpm[77:52],
  // speed_period_us[103:78], speed_pulse_total[135:104], vehicle_stopped[136], zeros above
  output logic [pctm_pkg::OUT_TDATA_W-1:0]         m_tdata,
  input  wire logic                                cfg_we,
  input  wire logic                                cfg_index,
  input  wire logic [pctm_pkg::CAP_W-1:0]          cfg_data
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CALC  = 6'b000010,
    ST_CHECK = 6'b000100,
    ST_DIV   = 6'b001000,
    ST_RPM   = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  state_t state;

  logic [pctm_pkg::CAP_W-1:0] inj_limit;
  logic [pctm_pkg::CAP_W-1:0] speed_limit;

  pctm_pkg::cmd_t             cmd;
  logic [pctm_pkg::CAP_W-1:0] first_cap;
  logic [pctm_pkg::CAP_W-1:0] second_cap;
  logic [pctm_pkg::CAP_W-1:0] diff;
  logic [pctm_pkg::CAP_W-1:0] per;

  logic [pctm_pkg::CAP_W-1:0] inj_last_open;
  logic                       inj_armed;
  logic [pctm_pkg::US_W-1:0]  inj_width;
  logic [pctm_pkg::US_W-1:0]  inj_period;
  logic [pctm_pkg::US_W-1:0]  rpm;
  logic [pctm_pkg::US_W-1:0]  speed_period;
  logic [pctm_pkg::CAP_W-1:0] speed_count;
  logic                       stopped;

  pctm_pkg::div_req_t         div_a_req;
  pctm_pkg::div_req_t         div_b_req;
  pctm_pkg::div_req_t         rdiv_req;
  pctm_pkg::div_rsp_t         div_a_rsp;
  pctm_pkg::div_rsp_t         div_b_rsp;
  pctm_pkg::div_rsp_t         rdiv_rsp;
  logic [pctm_pkg::CDIV_IN_W-1:0] div_a_in;
  logic [pctm_pkg::CDIV_IN_W-1:0] div_b_in;
  logic [pctm_pkg::US_W-1:0]  div_a_q;
  logic [pctm_pkg::US_W-1:0]  div_b_q;
  logic [pctm_pkg::US_W-1:0]  rdiv_q;

  logic [pctm_pkg::CDIV_IN_W-1:0] dbl;
  logic                           inj_ok;
  logic                           speed_ok;

  assign s_tready = (state == ST_IDLE);
  assign dbl      = {diff, 1'b0};
  assign inj_ok   = (diff <= inj_limit);
  assign speed_ok = (dbl < {1'b0, speed_limit});

  // Both tick dividers start together; the speed period uses only the first one.
  always_comb begin
    div_a_req.start = 1'b0;
    div_b_req.start = 1'b0;
    rdiv_req.start  = 1'b0;
    div_a_in        = {1'b0, diff};
    div_b_in        = {1'b0, per};
    if (state == ST_CHECK) begin
      if (cmd == pctm_pkg::CMD_INJ_PULSE) begin
        div_a_req.start = inj_ok;
        div_b_req.start = inj_ok;
      end else begin
        div_a_in        = dbl;
        div_a_req.start = speed_ok;
      end
    end
    if (state == ST_DIV && div_a_rsp.done && cmd == pctm_pkg::CMD_INJ_PULSE &&
        div_b_q != '0) begin
      rdiv_req.start = 1'b1;
    end
  end

  pctm_cdiv u_div_a (
    .clk      (clk),
    .rst      (rst),
    .req      (div_a_req),
    .dividend (div_a_in),
    .rsp      (div_a_rsp),
    .quotient (div_a_q)
  );

  pctm_cdiv u_div_b (
    .clk      (clk),
    .rst      (rst),
    .req      (div_b_req),
    .dividend (div_b_in),
    .rsp      (div_b_rsp),
    .quotient (div_b_q)
  );

  pctm_rdiv u_rdiv (
    .clk      (clk),
    .rst      (rst),
    .req      (rdiv_req),
    .divisor  (div_b_q),
    .rsp      (rdiv_rsp),
    .quotient (rdiv_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      inj_limit   <= '1;
      speed_limit <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        pctm_pkg::REG_INJ_WIDTH_LIMIT:    inj_limit   <= cfg_data;
        pctm_pkg::REG_SPEED_PERIOD_LIMIT: speed_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_tvalid      <= 1'b0;
      inj_last_open <= '0;
      inj_armed     <= 1'b0;
      inj_width     <= '0;
      inj_period    <= '0;
      rpm           <= '0;
      speed_period  <= '0;
      speed_count   <= '0;
      stopped       <= 1'b1;
    end else begin
      // The result load in ST_OUT takes over the valid flag in its own cycle.
      if (m_tvalid && m_tready && state != ST_OUT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            cmd        <= pctm_pkg::cmd_t'(s_tuser);
            first_cap  <= s_tdata[pctm_pkg::CAP_W-1:0];
            second_cap <= s_tdata[pctm_pkg::IN_TDATA_W-1:pctm_pkg::CAP_W];
            state      <= ST_CALC;
          end
        end
        ST_CALC: begin
          diff  <= second_cap - first_cap;
          per   <= first_cap - inj_last_open;
          state <= ST_OUT;
          case (cmd)
            pctm_pkg::CMD_INJ_PULSE: begin
              inj_last_open <= first_cap;
              inj_armed     <= 1'b1;
              if (inj_armed) begin
                state <= ST_CHECK;
              end
            end
            pctm_pkg::CMD_SPEED_PULSE: begin
              speed_count <= speed_count + 1'b1;
              if (stopped) begin
                stopped <= 1'b0;
              end else begin
                state <= ST_CHECK;
              end
            end
            pctm_pkg::CMD_INJ_TIMEOUT: begin
              inj_width     <= '0;
              inj_period    <= '0;
              rpm           <= '0;
              inj_last_open <= '0;
              inj_armed     <= 1'b0;
            end
            pctm_pkg::CMD_SPEED_TIMEOUT: begin
              speed_period <= '0;
              stopped      <= 1'b1;
            end
            default: ;
          endcase
        end
        ST_CHECK: begin
          if ((cmd == pctm_pkg::CMD_INJ_PULSE) ? inj_ok : speed_ok) begin
            state <= ST_DIV;
          end else begin
            state <= ST_OUT;
          end
        end
        ST_DIV: begin
          if (div_a_rsp.done) begin
            if (cmd == pctm_pkg::CMD_INJ_PULSE) begin
              inj_width  <= div_a_q;
              inj_period <= div_b_q;
              if (div_b_q != '0) begin
                state <= ST_RPM;
              end else begin
                rpm   <= '0;
                state <= ST_OUT;
              end
            end else begin
              speed_period <= div_a_q;
              state        <= ST_OUT;
            end
          end
        end
        ST_RPM: begin
          if (rdiv_rsp.done) begin
            rpm   <= rdiv_q;
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {{pctm_pkg::OUT_PAD{1'b0}}, stopped, speed_count, speed_period,
                         rpm, inj_period, inj_width};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ sv/pctm_checker.sv @@
// Port-level checks for the trip meter and their attachment to the top level.
`default_nettype none
module pctm_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              s_tvalid,
  input wire logic                              s_tready,
  input wire logic                              m_tvalid,
  input wire logic                              m_tready,
  input wire logic [pctm_pkg::OUT_TDATA_W-1:0]  m_tdata
);

  // A result word waiting for the sink holds its value.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
  else $error("result word changed while stalled");

  // Only one event is in work: ready drops right after a word is taken.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
  else $error("input taken while an event is in work");

  // A stopped vehicle never reports a speed period.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[pctm_pkg::OUT_STOPPED_BIT] |->
      m_tdata[pctm_pkg::OUT_SPEED_LSB +: pctm_pkg::US_W] == '0)
  else $error("speed period reported while stopped");

  // No injector period means no rpm.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[pctm_pkg::OUT_PERIOD_LSB +: pctm_pkg::US_W] == '0 |->
      m_tdata[pctm_pkg::OUT_RPM_LSB +: pctm_pkg::US_W] == '0)
  else $error("rpm reported without an injector period");

endmodule

bind pulse_capture_trip_meter_unit pctm_checker u_pctm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire
